@@ src/sil_pkg.sv @@
// sil_pkg: shared types and constants for the sorted index list.
// Used by sil_cell and sorted_index_list; depends on nothing else.
package sil_pkg;

   localparam int SIL_CAPACITY  = 16;
   localparam int VALUE_W       = 8;
   localparam int ENTRY_COUNT_W = 5;

   // action codes carried on req_tuser
   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_REMOVE = 2'd2
   } action_type;

   // status codes carried on rsp_tuser
   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert_en;   // insert accepted and list not full
      logic remove_en;   // remove accepted and a match exists
   } cell_ctl_type;

endpackage

@@ src/sil_cell.sv @@
// sil_cell: one slot of the sorted list, holding a single entry.
// Depends on sil_pkg; instantiated as a row by sorted_index_list.
module sil_cell
   import sil_pkg::*;
(
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic [VALUE_W-1:0] value,
   input  logic               valid,        // slot index below the count
   input  logic               left_lt,      // left neighbor holds an entry below value
   input  logic [VALUE_W-1:0] left_entry,
   input  logic [VALUE_W-1:0] right_entry,
   output logic [VALUE_W-1:0] entry,
   output logic               lt,
   output logic               eq
);

   logic [VALUE_W-1:0] entry_ff;
   logic [VALUE_W-1:0] entry_in;

   // compare the held entry against the broadcast value
   assign lt    = valid && (entry_ff < value);
   assign eq    = valid && (entry_ff == value);
   assign entry = entry_ff;

   // slots at or past the insert point shift right, the insert point takes value;
   // slots at or past the first match shift left on remove
   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert_en && !lt) begin
         entry_in = left_lt ? value : left_entry;
      end else if (ctl.remove_en && !lt) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ src/sorted_index_list.sv @@
// sorted_index_list: ascending list of 8-bit indices, insert / remove / clear.
// A result word is registered and valid in the cycle after its request is accepted.
// Throughput: one request word per cycle; every slot of the cell row updates in
// the same cycle, and the single result register holds back only while unread.
// Reset: synchronous, clears the count and the result valid; entries need no reset.
// Depends on sil_pkg and sil_cell.
module sorted_index_list
   import sil_pkg::*;
#(
   parameter int CAPACITY = SIL_CAPACITY
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] value
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [4:0] entry_count, [7:5] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ENTRY_COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   status_type               rsp_status_ff, rsp_status_in;

   logic               accept;
   logic [VALUE_W-1:0] value;
   logic               full;
   logic               found;
   cell_ctl_type       ctl;
   status_type         status;

   logic [VALUE_W-1:0]  entry_w [CAPACITY];
   logic [CAPACITY-1:0] lt_w;
   logic [CAPACITY-1:0] eq_w;

   assign value      = req_tdata[VALUE_W-1:0];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff >= CNT_W'(CAPACITY));
   assign found      = |eq_w;

   // decode the action and work out the new count
   always_comb begin
      ctl      = '0;
      status   = ST_DONE;
      count_in = count_ff;
      case (req_tuser)
         ACT_CLEAR: begin
            if (accept) count_in = '0;
         end
         ACT_INSERT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               ctl.insert_en = accept;
               if (accept) count_in = count_ff + CNT_W'(1);
            end
         end
         ACT_REMOVE: begin
            if (!found) begin
               status = ST_MISS;
            end else begin
               ctl.remove_en = accept;
               if (accept) count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
            status = ST_DONE;
         end
      endcase
   end

   // row of cells, each wired to its neighbors
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic               left_lt;
      logic [VALUE_W-1:0] left_entry;
      logic [VALUE_W-1:0] right_entry;

      if (i == 0) begin : g_first
         assign left_lt    = 1'b1;
         assign left_entry = value;
      end else begin : g_mid_l
         assign left_lt    = lt_w[i-1];
         assign left_entry = entry_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = value;
      end else begin : g_mid_r
         assign right_entry = entry_w[i+1];
      end

      sil_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .value       (value),
         .valid       (CNT_W'(i) < count_ff),
         .left_lt     (left_lt),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entry_w[i]),
         .lt          (lt_w[i]),
         .eq          (eq_w[i])
      );
   end

   // result register: load on accept, drop when taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_count_in  = ENTRY_COUNT_W'(count_in);
         rsp_status_in = status;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(8 - ENTRY_COUNT_W){1'b0}}, rsp_count_ff};
   assign rsp_tuser  = rsp_status_ff;

   // checks on count and result bookkeeping
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("count exceeds capacity");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser == ACT_INSERT && full |=>
         rsp_status_ff == ST_FULL && $stable(count_ff))
      else $error("insert into full list not rejected");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser == ACT_CLEAR |=> count_ff == '0)
      else $error("clear did not empty list");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted word produced no result");

endmodule
